// ----- hdl/htfd_pkg.sv -----
// htfd_pkg: shared types, constants and the crc-8 step for the frame decoder
// no dependencies; imported by htfd_frame, htfd_scale and the top level
package htfd_pkg;

  localparam logic [7:0]  CRC_POLY   = 8'h31;
  localparam logic [7:0]  CRC_INIT   = 8'hFF;

  localparam logic [14:0] TEMP_SCALE  = 15'd17500;
  localparam logic [14:0] TEMP_OFFSET = 15'd4500;
  localparam logic [13:0] HUM_SCALE   = 14'd12500;
  localparam logic [13:0] HUM_OFFSET  = 14'd600;
  localparam logic [13:0] HUM_MAX     = 14'd10000;
  localparam logic [16:0] DIV_CONST   = 17'd65535;

  // position of the next byte within the six-byte frame
  typedef enum logic [2:0] {
    POS_T_HI  = 3'd0,
    POS_T_LO  = 3'd1,
    POS_T_CRC = 3'd2,
    POS_H_HI  = 3'd3,
    POS_H_LO  = 3'd4,
    POS_H_CRC = 3'd5
  } pos_t;

  // status of the byte being processed this cycle
  typedef struct packed {
    logic last;   // byte closes the frame, a result follows
    logic ok;     // both word crcs matched
  } htfd_status_t;

  // crc-8, msb first, one byte folded in
  function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- hdl/htfd_frame.sv -----
// htfd_frame: byte position tracking, running crc and raw word capture
// depends on htfd_pkg
module htfd_frame (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  go,
  input  logic [7:0]            rx_byte,
  input  logic                  frame_start,
  output htfd_pkg::htfd_status_t status,
  output logic [15:0]           temp_raw,
  output logic [15:0]           hum_raw
);
  import htfd_pkg::*;

  pos_t        pos_r, pos_nxt, pos_eff;
  logic [7:0]  crc_r, crc_nxt;
  logic [15:0] temp_raw_r, temp_raw_nxt;
  logic [15:0] hum_raw_r, hum_raw_nxt;
  logic        first_ok_r, first_ok_nxt;
  logic        crc_match;

  always_comb begin
    if (frame_start || (pos_r > POS_H_CRC)) begin
      pos_eff = POS_T_HI;
    end else begin
      pos_eff = pos_r;
    end
  end

  assign crc_match = (crc_r == rx_byte);

  always_comb begin
    pos_nxt      = pos_r;
    crc_nxt      = crc_r;
    temp_raw_nxt = temp_raw_r;
    hum_raw_nxt  = hum_raw_r;
    first_ok_nxt = first_ok_r;
    if (go) begin
      pos_nxt = pos_t'(pos_eff + 3'd1);
      case (pos_eff)
        POS_T_HI: begin
          crc_nxt      = crc_feed(CRC_INIT, rx_byte);
          temp_raw_nxt = {rx_byte, 8'h00};
        end
        POS_T_LO: begin
          crc_nxt      = crc_feed(crc_r, rx_byte);
          temp_raw_nxt = {temp_raw_r[15:8], rx_byte};
        end
        POS_T_CRC: begin
          first_ok_nxt = crc_match;
          crc_nxt      = CRC_INIT;
        end
        POS_H_HI: begin
          crc_nxt     = crc_feed(CRC_INIT, rx_byte);
          hum_raw_nxt = {rx_byte, 8'h00};
        end
        POS_H_LO: begin
          crc_nxt     = crc_feed(crc_r, rx_byte);
          hum_raw_nxt = {hum_raw_r[15:8], rx_byte};
        end
        default: begin
          pos_nxt = POS_T_HI;
          crc_nxt = CRC_INIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= POS_T_HI;
      crc_r      <= CRC_INIT;
      temp_raw_r <= 16'h0000;
      hum_raw_r  <= 16'h0000;
      first_ok_r <= 1'b0;
    end else begin
      pos_r      <= pos_nxt;
      crc_r      <= crc_nxt;
      temp_raw_r <= temp_raw_nxt;
      hum_raw_r  <= hum_raw_nxt;
      first_ok_r <= first_ok_nxt;
    end
  end

  assign status.last = (pos_eff == POS_H_CRC);
  assign status.ok   = first_ok_r && crc_match;
  assign temp_raw    = temp_raw_r;
  assign hum_raw     = hum_raw_r;

endmodule

// ----- hdl/htfd_scale.sv -----
// htfd_scale: raw words to centi-degrees and clamped centi-percent
// depends on htfd_pkg; divide by 65535 is shift, add and one correction
module htfd_scale (
  input  logic [15:0]        temp_raw,
  input  logic [15:0]        hum_raw,
  output logic signed [14:0] temp_centi,
  output logic [13:0]        hum_centi
);
  import htfd_pkg::*;

  logic [30:0] t_prod;
  logic [14:0] t_q0, t_q;
  logic [16:0] t_rem;
  logic [29:0] h_prod;
  logic [13:0] h_q0, h_q, h_diff;
  logic [16:0] h_rem;

  // quotient estimate p>>16, remainder (p mod 2^16) + q0 stays below 2*65535
  assign t_prod = 31'(temp_raw) * 31'(TEMP_SCALE);
  assign t_q0   = t_prod[30:16];
  assign t_rem  = {1'b0, t_prod[15:0]} + {2'b00, t_q0};
  assign t_q    = t_q0 + 15'(t_rem >= DIV_CONST);

  assign h_prod = 30'(hum_raw) * 30'(HUM_SCALE);
  assign h_q0   = h_prod[29:16];
  assign h_rem  = {1'b0, h_prod[15:0]} + {3'b000, h_q0};
  assign h_q    = h_q0 + 14'(h_rem >= DIV_CONST);

  assign temp_centi = signed'(t_q - TEMP_OFFSET);

  assign h_diff = h_q - HUM_OFFSET;

  always_comb begin
    if (h_q < HUM_OFFSET) begin
      hum_centi = 14'd0;
    end else if (h_diff > HUM_MAX) begin
      hum_centi = HUM_MAX;
    end else begin
      hum_centi = h_diff;
    end
  end

endmodule

// ----- hdl/humidity_temp_frame_decoder.sv -----
// humidity_temp_frame_decoder: six-byte measurement frame to checked readings
// the result word is loaded into the result register when the sixth byte leaves the input register
// throughput: one byte per cycle unless out_stall holds back the last byte of a frame
// reset: synchronous active-low rst_n clears the valid flags of both pipeline registers,
// byte count 0, crc to 0xff; depends on htfd_pkg, htfd_frame and htfd_scale
module humidity_temp_frame_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  input  logic               in_frame_start,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_reading_valid,
  output logic signed [14:0] out_temperature_centi,
  output logic [13:0]        out_humidity_centi
);
  import htfd_pkg::*;

  // input register
  logic        in_vld_r, in_vld_nxt;
  logic [7:0]  byte_r;
  logic        start_r;

  // result register
  logic               out_vld_r, out_vld_nxt;
  logic               ok_r;
  logic signed [14:0] temp_r;
  logic [13:0]        hum_r;

  htfd_status_t       status;
  logic [15:0]        temp_raw, hum_raw;
  logic signed [14:0] temp_centi;
  logic [13:0]        hum_centi;
  logic               proc_go;
  logic               load_out;

  // a byte that gives no result never waits on the output side
  assign proc_go  = in_vld_r && (!status.last || !out_vld_r || !out_stall);
  assign load_out = proc_go && status.last;
  assign in_stall = in_vld_r && !proc_go;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (!in_stall) begin
      in_vld_nxt = in_valid;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (load_out) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload capture, no reset needed
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      byte_r  <= in_rx_byte;
      start_r <= in_frame_start;
    end
  end

  // frame tracking: byte count, crc check, raw words
  htfd_frame u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .go          (proc_go),
    .rx_byte     (byte_r),
    .frame_start (start_r),
    .status      (status),
    .temp_raw    (temp_raw),
    .hum_raw     (hum_raw)
  );

  // conversion works on the stored words, ready before the last crc byte
  htfd_scale u_scale (
    .temp_raw   (temp_raw),
    .hum_raw    (hum_raw),
    .temp_centi (temp_centi),
    .hum_centi  (hum_centi)
  );

  // failed crc gives an all-zero reading
  always_ff @(posedge clk) begin
    if (load_out) begin
      ok_r   <= status.ok;
      temp_r <= status.ok ? temp_centi : 15'sd0;
      hum_r  <= status.ok ? hum_centi : 14'd0;
    end
  end

  assign out_valid             = out_vld_r;
  assign out_reading_valid     = ok_r;
  assign out_temperature_centi = temp_r;
  assign out_humidity_centi    = hum_r;

endmodule
